// ===== src/mtrq_pkg.sv =====
// Shared types and codes for the transmit retry queue.
package mtrq_pkg;

    // Queue size and node space; node ids at or above NODE_COUNT are used as they are
    localparam int QUEUE_DEPTH = 16;
    localparam int NODE_COUNT  = 64;

    typedef enum logic [3:0] {
        OP_INSERT = 4'd0,
        OP_FIND   = 4'd1,
        OP_PEEK   = 4'd2,
        OP_MARK   = 4'd3,
        OP_REMOVE = 4'd4,
        OP_INCR   = 4'd5,
        OP_DROP   = 4'd6,
        OP_COUNT  = 4'd7,
        OP_CLEAR  = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_NOTHING  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,       // read issued, data arrives next cycle
        S_SCAN,     // examine entry, maybe write or report
        S_SHIFT_RD, // compaction: read entry above the hole
        S_SHIFT_WR, // compaction: write it one slot lower
        S_CLR
    } t_state;

    localparam logic [1:0] REG_LIMIT   = 2'd0;
    localparam logic [1:0] REG_RETRIES = 2'd1;

endpackage

// ===== src/mac_tx_retry_queue.sv =====
// Top level of the transmit retry queue: register port, entry memory, sequencer.
//
// Queue entries live in one synchronous memory (one read, one write port, read data
// registered). Insert, unknown codes and clear of an empty queue answer in the accept
// cycle. Find, peek, mark, remove, increment, count and drop walk the memory from the
// front, reading each entry and then examining it; clear walks from the back, reporting
// one entry per cycle. Remove and drop compact the queue by copying each later entry
// down one slot, reading it and then writing it; a remove reports first and stays busy
// while compaction finishes. busy is high from the cycle after accept until the item is
// done. Results appear on o_valid for one cycle; the receiver cannot stall them, and
// o_last marks the final result of an item.
module mac_tx_retry_queue
    import mtrq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] i_opcode,
    input  logic [5:0] i_node_id,
    input  logic [7:0] i_packet_handle,
    input  logic [5:0] i_packet_destination,
    input  logic       i_packet_is_broadcast,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [7:0] o_handle_out,
    output logic [5:0] o_destination_out,
    output logic       o_broadcast_out,
    output logic       o_dropped_unicast,
    output logic [4:0] o_unicast_count,
    output logic [4:0] o_broadcast_count,
    output logic       o_last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  handle;
        logic [5:0]  dest;
        logic        bcast;
        logic [7:0]  att;
        logic [63:0] sent;
    } t_entry;

    // entry memory
    t_entry mem [QUEUE_DEPTH];
    t_entry r_rdata;
    logic   mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    t_entry mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    // configuration registers
    logic [4:0] r_limit;
    logic [7:0] r_retries;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= 5'd16;
            r_retries <= 8'd3;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_LIMIT[0]) r_limit <= pwdata[4:0];
            else                          r_retries <= pwdata[7:0];
        end
    end
    always_comb begin
        prdata = (paddr[2] == REG_LIMIT[0]) ? {27'd0, r_limit} : {24'd0, r_retries};
    end

    // sequencer registers
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [5:0] r_node, n_node;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_idx, n_idx;   // entry under examination
    logic [LW-1:0] r_mv, n_mv;     // compaction source index
    logic [4:0] r_uc, n_uc, r_bc, n_bc;
    logic r_any, n_any;            // drop: a removed entry waits to be reported
    logic [7:0] r_dh, n_dh;        // drop: held report
    logic [5:0] r_dd, n_dd;
    logic r_db, n_db;

    logic [LW-1:0] lim_eff;
    assign lim_eff = (int'(r_limit) > QUEUE_DEPTH) ? LW'(QUEUE_DEPTH) : LW'(r_limit);

    logic nsent, hit, expire;
    logic [63:0] nodebit;
    always_comb begin
        nodebit = 64'd1 << r_node;
        nsent   = (r_rdata.sent & nodebit) == 64'd0;
        expire  = r_rdata.bcast ? (r_rdata.att != 8'd0) : (r_rdata.att >= r_retries);
        unique case (r_op)
            OP_FIND:   hit = (r_rdata.bcast && nsent) || (r_rdata.dest == r_node);
            OP_PEEK:   hit = !r_rdata.bcast;
            OP_MARK:   hit = r_rdata.bcast && nsent;
            OP_REMOVE: hit = r_rdata.dest == r_node;
            default:   hit = 1'b0;
        endcase
    end

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
        r_op <= n_op; r_node <= n_node; r_idx <= n_idx; r_mv <= n_mv;
        r_uc <= n_uc; r_bc <= n_bc; r_any <= n_any;
        r_dh <= n_dh; r_dd <= n_dd; r_db <= n_db;
    end

    // next state and results
    always_comb begin
        n_state = r_state; n_op = r_op; n_node = r_node; n_len = r_len;
        n_idx = r_idx; n_mv = r_mv; n_uc = r_uc; n_bc = r_bc; n_any = r_any;
        n_dh = r_dh; n_dd = r_dd; n_db = r_db;
        mem_we = 1'b0; mem_wa = r_idx[AW-1:0]; mem_wd = r_rdata;
        mem_ra = r_idx[AW-1:0];
        o_valid = 1'b0; o_status = ST_OK; o_handle_out = '0; o_destination_out = '0;
        o_broadcast_out = 1'b0; o_dropped_unicast = 1'b0; o_unicast_count = '0;
        o_broadcast_count = '0; o_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = t_op'(i_opcode); n_node = i_node_id;
                    n_idx = '0; n_uc = '0; n_bc = '0; n_any = 1'b0;
                    mem_ra = '0;
                    if (i_opcode == OP_INSERT) begin
                        o_valid = 1'b1; o_last = 1'b1;
                        o_handle_out = i_packet_handle;
                        o_destination_out = i_packet_destination;
                        o_broadcast_out = i_packet_is_broadcast;
                        if (r_len >= lim_eff) o_status = ST_FULL;
                        else begin
                            mem_we = 1'b1; mem_wa = r_len[AW-1:0];
                            mem_wd = '{handle: i_packet_handle,
                                       dest: i_packet_destination,
                                       bcast: i_packet_is_broadcast,
                                       att: 8'd0, sent: 64'd0};
                            n_len = r_len + 1'b1;
                        end
                    end else if (i_opcode == OP_CLEAR) begin
                        if (r_len == '0) begin
                            o_valid = 1'b1; o_last = 1'b1; o_status = ST_NOTHING;
                        end else begin
                            n_idx = r_len - 1'b1;
                            mem_ra = n_idx[AW-1:0];
                            n_state = S_CLR;
                        end
                    end else if (i_opcode > OP_CLEAR) begin
                        o_valid = 1'b1; o_last = 1'b1; o_status = ST_NOTFOUND;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                // read of r_idx issued last cycle
                if (r_idx >= r_len) begin
                    o_valid = 1'b1; o_last = 1'b1; n_state = S_IDLE;
                    unique case (r_op)
                        OP_INCR:  o_status = ST_OK;
                        OP_COUNT: begin
                            o_status = ST_OK;
                            o_unicast_count = r_uc; o_broadcast_count = r_bc;
                        end
                        OP_DROP:  begin
                            // final drop report, or nothing was dropped
                            if (r_any) begin
                                o_status = ST_OK;
                                o_handle_out = r_dh;
                                o_destination_out = r_dd;
                                o_broadcast_out = r_db;
                                o_dropped_unicast = !r_db;
                            end else begin
                                o_status = ST_NOTHING;
                            end
                        end
                        default:  o_status = ST_NOTFOUND;
                    endcase
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                mem_ra = n_idx[AW-1:0];
                n_state = S_RD;
                unique case (r_op)
                    OP_INCR: begin
                        mem_we = 1'b1;
                        if (r_rdata.att != 8'hFF) mem_wd.att = r_rdata.att + 8'd1;
                    end
                    OP_COUNT: begin
                        if (r_rdata.bcast) n_bc = r_bc + 5'd1;
                        else               n_uc = r_uc + 5'd1;
                    end
                    OP_DROP: begin
                        if (expire) begin
                            // report the previously held entry, hold this one
                            if (r_any) begin
                                o_valid = 1'b1; o_status = ST_OK;
                                o_handle_out = r_dh;
                                o_destination_out = r_dd;
                                o_broadcast_out = r_db;
                                o_dropped_unicast = !r_db;
                            end
                            n_dh = r_rdata.handle;
                            n_dd = r_rdata.dest;
                            n_db = r_rdata.bcast;
                            n_any = 1'b1;
                            n_idx = r_idx; n_mv = r_idx + 1'b1;
                            mem_ra = n_mv[AW-1:0];
                            n_state = S_SHIFT_RD;
                        end
                    end
                    default: begin
                        if (hit) begin
                            o_valid = 1'b1; o_last = 1'b1; o_status = ST_OK;
                            o_handle_out = r_rdata.handle;
                            o_destination_out = r_rdata.dest;
                            o_broadcast_out = r_rdata.bcast;
                            n_state = S_IDLE;
                            if (r_op == OP_MARK) begin
                                mem_we = 1'b1; mem_wd.sent = r_rdata.sent | nodebit;
                            end else if (r_op == OP_REMOVE) begin
                                n_idx = r_idx; n_mv = r_idx + 1'b1;
                                mem_ra = n_mv[AW-1:0];
                                n_state = S_SHIFT_RD;
                            end
                        end
                    end
                endcase
            end
            S_SHIFT_RD: begin
                // read of r_mv issued; finish when beyond the queue
                if (r_mv >= r_len) begin
                    n_len = r_len - 1'b1;
                    mem_ra = r_idx[AW-1:0];
                    n_state = (r_op == OP_DROP) ? S_RD : S_IDLE;
                end else begin
                    mem_ra = r_mv[AW-1:0];
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_mv - 1'b1);
                n_mv = r_mv + 1'b1;
                mem_ra = n_mv[AW-1:0];
                n_state = S_SHIFT_RD;
            end
            S_CLR: begin
                o_valid = 1'b1; o_status = ST_OK;
                o_handle_out = r_rdata.handle;
                o_destination_out = r_rdata.dest;
                o_broadcast_out = r_rdata.bcast;
                n_len = r_len - 1'b1;
                if (r_idx == '0) begin
                    o_last = 1'b1; n_state = S_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                    mem_ra = n_idx[AW-1:0];
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
